FILE: hw/rtl/complex_fir_filter_real_taps_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the complex FIR filter
// Clocked assertion shorthands, with and without the reset qualifier
// ----------------------------------------------------------------------------
`ifndef COMPLEX_FIR_FILTER_REAL_TAPS_UNIT_ASSERT_SVH
`define COMPLEX_FIR_FILTER_REAL_TAPS_UNIT_ASSERT_SVH

// checked only while out of reset
`define CFRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define CFRT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/cfrt_pkg.sv
// ----------------------------------------------------------------------------
// cfrt_pkg
// Types and constants shared by the complex FIR filter with real taps
// ----------------------------------------------------------------------------
package cfrt_pkg;

  localparam int NUM_TAPS  = 8;
  localparam int TAP_REGS  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int SMP_W     = 16;
  localparam int PROD_W    = 2 * SMP_W;
  localparam int ACC_W     = PROD_W + $clog2(NUM_TAPS) + 1;
  localparam int EXT_W     = ACC_W - PROD_W;
  localparam int FRAC_W    = SMP_W - 1;
  localparam int RND_W     = ACC_W + 1;
  localparam int QUO_W     = RND_W - FRAC_W;

  localparam logic signed [SMP_W-1:0] TAP0_RST = 16'sh7fff;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_re;
    logic signed [SMP_W-1:0] sample_im;
  } sample_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] out_re;
    logic signed [SMP_W-1:0] out_im;
  } result_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;
  } acc_pair_t;

  // partial sum handed from one cell to the next
  typedef struct packed {
    logic      vld;
    acc_pair_t sum;
  } link_t;

endpackage

FILE: hw/rtl/cfrt_tap_cell.sv
// ----------------------------------------------------------------------------
// cfrt_tap_cell
// One tap of the delay line: holds a sample, weighs it, adds to the passing sum
// ----------------------------------------------------------------------------
module cfrt_tap_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                shift_en,
  input  cfrt_pkg::sample_t                   smp_in,
  output cfrt_pkg::sample_t                   smp_out,
  input  logic signed [cfrt_pkg::SMP_W-1:0]   tap,
  input  cfrt_pkg::link_t                     link_in,
  output cfrt_pkg::link_t                     link_out
);

  cfrt_pkg::sample_t                   hist_r, hist_nxt;
  logic signed [cfrt_pkg::PROD_W-1:0]  prod_re_r, prod_re_nxt;
  logic signed [cfrt_pkg::PROD_W-1:0]  prod_im_r, prod_im_nxt;
  logic                                vld_r, vld_nxt;
  cfrt_pkg::acc_pair_t                 sum_r, sum_nxt;

  always_comb begin
    hist_nxt    = shift_en ? smp_in : hist_r;
    prod_re_nxt = hist_r.sample_re * tap;
    prod_im_nxt = hist_r.sample_im * tap;
    vld_nxt     = link_in.vld;
    sum_nxt     = sum_r;
    if (link_in.vld) begin
      sum_nxt.acc_re = link_in.sum.acc_re
                     + {{cfrt_pkg::EXT_W{prod_re_r[cfrt_pkg::PROD_W-1]}}, prod_re_r};
      sum_nxt.acc_im = link_in.sum.acc_im
                     + {{cfrt_pkg::EXT_W{prod_im_r[cfrt_pkg::PROD_W-1]}}, prod_im_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      hist_r <= hist_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_re_r <= prod_re_nxt;
    prod_im_r <= prod_im_nxt;
    sum_r     <= sum_nxt;
  end

  assign smp_out      = hist_r;
  assign link_out.vld = vld_r;
  assign link_out.sum = sum_r;

endmodule

FILE: hw/rtl/cfrt_rnd_sat.sv
// ----------------------------------------------------------------------------
// cfrt_rnd_sat
// Rounds a Q.30 sum to nearest (ties up) and saturates it to Q1.15
// ----------------------------------------------------------------------------
module cfrt_rnd_sat (
  input  logic signed [cfrt_pkg::ACC_W-1:0]  acc,
  output logic signed [cfrt_pkg::SMP_W-1:0]  res
);

  logic [cfrt_pkg::RND_W-1:0] rnd;
  logic [cfrt_pkg::QUO_W-1:0] quo;
  logic                       ovf_hi;
  logic                       ovf_lo;

  always_comb begin
    rnd    = {acc[cfrt_pkg::ACC_W-1], acc}
           + (cfrt_pkg::RND_W'(1) << (cfrt_pkg::FRAC_W - 1));
    quo    = rnd[cfrt_pkg::RND_W-1:cfrt_pkg::FRAC_W];
    // value fits when the bits above the result all equal its sign
    ovf_hi = !quo[cfrt_pkg::QUO_W-1] && (|quo[cfrt_pkg::QUO_W-2:cfrt_pkg::SMP_W-1]);
    ovf_lo = quo[cfrt_pkg::QUO_W-1] && !(&quo[cfrt_pkg::QUO_W-2:cfrt_pkg::SMP_W-1]);
    priority if (ovf_hi) begin
      res = {1'b0, {(cfrt_pkg::SMP_W-1){1'b1}}};
    end else if (ovf_lo) begin
      res = {1'b1, {(cfrt_pkg::SMP_W-1){1'b0}}};
    end else begin
      res = quo[cfrt_pkg::SMP_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/complex_fir_filter_real_taps_unit.sv
// ----------------------------------------------------------------------------
// complex_fir_filter_real_taps_unit
// Direct-form FIR on complex samples with real Q1.15 taps, as a row of cells
// ----------------------------------------------------------------------------
// an accepted sample passes start, go, the row of tap cells (the partial sum
//   ripples one cell per cycle), the holding and the output registers to
//   out_valid; in_ready stays low until the result enters the output register
// a finished result waits in a holding register while the output is stalled
// reset clears the delay line, the taps (tap_0 = 32767, rest 0) and control
module complex_fir_filter_real_taps_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cfrt_pkg::sample_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cfrt_pkg::result_t                   out_data,
  input  logic                                cfg_we,
  input  logic [cfrt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfrt_pkg::SMP_W-1:0]          cfg_data
);

  logic signed [cfrt_pkg::SMP_W-1:0] tap_r   [cfrt_pkg::TAP_REGS];
  logic signed [cfrt_pkg::SMP_W-1:0] tap_nxt [cfrt_pkg::TAP_REGS];

  logic busy_r, busy_nxt;
  logic start_r, start_nxt;
  logic go_r, go_nxt;
  logic pend_v_r, pend_v_nxt;
  logic out_valid_r, out_valid_nxt;
  cfrt_pkg::result_t pend_r, pend_nxt;
  cfrt_pkg::result_t out_r, out_nxt;
  cfrt_pkg::result_t rnd_w;

  logic accept;
  logic xfer;

  cfrt_pkg::sample_t smp_in_w [cfrt_pkg::NUM_TAPS];
  cfrt_pkg::sample_t hist_w   [cfrt_pkg::NUM_TAPS];
  cfrt_pkg::link_t   link_w   [cfrt_pkg::NUM_TAPS+1];

  assign accept   = in_valid && in_ready;
  assign in_ready = !busy_r;
  assign xfer     = pend_v_r && (!out_valid_r || out_ready);

  // tap registers
  always_comb begin
    for (int i = 0; i < cfrt_pkg::TAP_REGS; i++) begin
      tap_nxt[i] = tap_r[i];
    end
    if (cfg_we) begin
      tap_nxt[cfg_index] = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r[0] <= cfrt_pkg::TAP0_RST;
      for (int i = 1; i < cfrt_pkg::TAP_REGS; i++) begin
        tap_r[i] <= '0;
      end
    end else begin
      tap_r <= tap_nxt;
    end
  end

  // row of tap cells; the sum enters cell 0 after the shift, via start and go
  assign link_w[0].vld = go_r;
  assign link_w[0].sum = '0;

  for (genvar k = 0; k < cfrt_pkg::NUM_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign smp_in_w[k] = in_data;
    end else begin : g_body
      assign smp_in_w[k] = hist_w[k-1];
    end

    cfrt_tap_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .smp_in   (smp_in_w[k]),
      .smp_out  (hist_w[k]),
      .tap      (tap_r[k]),
      .link_in  (link_w[k]),
      .link_out (link_w[k+1])
    );
  end

  cfrt_rnd_sat u_rnd_re (
    .acc (link_w[cfrt_pkg::NUM_TAPS].sum.acc_re),
    .res (rnd_w.out_re)
  );

  cfrt_rnd_sat u_rnd_im (
    .acc (link_w[cfrt_pkg::NUM_TAPS].sum.acc_im),
    .res (rnd_w.out_im)
  );

  // control and result staging
  always_comb begin
    start_nxt     = accept;
    go_nxt        = start_r;
    busy_nxt      = busy_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (accept) begin
      busy_nxt = 1'b1;
    end else if (xfer) begin
      busy_nxt = 1'b0;
    end

    if (link_w[cfrt_pkg::NUM_TAPS].vld) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = rnd_w;
    end else if (xfer) begin
      pend_v_nxt = 1'b0;
    end

    if (xfer) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pend_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      go_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      start_r     <= start_nxt;
      go_r        <= go_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/cfrt_checker.sv
// ----------------------------------------------------------------------------
// cfrt_checker
// Port-level checks for the complex FIR filter, bound to the top level
// ----------------------------------------------------------------------------
`include "complex_fir_filter_real_taps_unit_assert.svh"

module cfrt_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  cfrt_pkg::result_t               out_data
);

  // a result held back by the sink stays put
  `CFRT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "output request dropped or changed while stalled")

  // one request in flight: the input closes right after a request
  `CFRT_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready ##1 !in_ready, "input reopened while a request is in flight")

  // a new result only appears while a request is being worked on
  `CFRT_ASSERT(a_result_from_work, $rose(out_valid) |-> !$past(in_ready), "result appeared with no request in flight")

  // reset empties the output
  `CFRT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind complex_fir_filter_real_taps_unit cfrt_checker u_cfrt_checker (.*);
